[hw/rtl/sidr_pkg.sv]
// sidr_pkg: shared types and constants for the sharded id registry
// no dependencies; used by sharded_id_registry_unit
package sidr_pkg;

  localparam int unsigned ID_W     = 64;
  localparam int unsigned SID_W    = 8;
  localparam int unsigned CFG_W    = 3;
  // shard select comes from at most this many bits of the upper id word
  localparam int unsigned SEL_W    = 7;
  localparam int unsigned SEL_LSB  = 32;
  localparam int unsigned SEL_N    = 1 << SEL_W;

  localparam logic CMD_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NEW     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_e;

endpackage

[hw/rtl/sidr_ram.sv]
// sidr_ram: generic single write port, single read port ram with registered read
// no dependencies; instanced by sharded_id_registry_unit
module sidr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sharded_id_registry_unit.sv]
// sharded_id_registry_unit: top level of the sharded id registry
// depends on sidr_pkg and sidr_ram
//
// Maps 64-bit user ids to small indices. A word carries a command (register or
// find) and an id; the shard is picked by the low shard_bits bits of id[38:32]
// taken modulo MAX_SHARDS. The shard's slot list is probed one slot per cycle
// through a three-stage read pipeline (slot ram, id ram, 64-bit compare). On a
// miss the result is loaded after the shard fill read, the probe of every
// filled slot and the insert decision; on a hit it is loaded after the
// matching slot compares equal. The block takes one word at a time and can
// take the next one the cycle after the result is loaded. in_ready_o is low
// while a word is being worked on or while its result cannot yet be placed in
// the output register. An id that a register word brings and that the shard
// does not hold yet is appended at the next global index, unless the store or
// the shard is full. shard_bits should only be written while the registry is
// empty and the block is idle.
module sharded_id_registry_unit #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned MAX_SHARDS  = 16,
  parameter int unsigned SHARD_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sidr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [sidr_pkg::ID_W-1:0] user_id_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [sidr_pkg::SID_W-1:0] stream_id_o
);

  localparam int unsigned IW         = $clog2(CAPACITY);
  localparam int unsigned CW         = $clog2(CAPACITY + 1);
  localparam int unsigned FW         = $clog2(SHARD_SLOTS + 1);
  localparam int unsigned SHW        = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
  localparam int unsigned SLOT_DEPTH = MAX_SHARDS * SHARD_SLOTS;
  localparam int unsigned SAW        = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  // shard number for every possible select value, reduced modulo MAX_SHARDS
  function automatic logic [sidr_pkg::SEL_N-1:0][SHW-1:0] mod_table();
    logic [sidr_pkg::SEL_N-1:0][SHW-1:0] t;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < sidr_pkg::SEL_N; i++) begin
      t[i] = SHW'(r);
      r = r + 1;
      if (r == MAX_SHARDS) begin
        r = 0;
      end
    end
    return t;
  endfunction

  localparam logic [sidr_pkg::SEL_N-1:0][SHW-1:0] SHARD_OF = mod_table();

  sidr_pkg::state_e  state_q, state_d;
  sidr_pkg::status_e res_status_q, res_status_d;

  logic [sidr_pkg::CFG_W-1:0] shard_bits_q;
  logic [CW-1:0]              total_q, total_d;
  logic [MAX_SHARDS-1:0]      fvalid_q, fvalid_d;
  logic                       p1_v_q, p1_v_d;
  logic                       p2_v_q, p2_v_d;
  logic                       out_valid_q, out_valid_d;

  logic [sidr_pkg::ID_W-1:0]  id_q;
  logic                       cmd_q;
  logic [SHW-1:0]             shard_q, shard_d;
  logic [SAW-1:0]             base_q;
  logic [FW-1:0]              fill_q, fill_d;
  logic [FW-1:0]              k_q, k_d;
  logic [IW-1:0]              p2_idx_q;
  logic [IW-1:0]              res_idx_q, res_idx_d;
  logic [1:0]                 status_q;
  logic [sidr_pkg::SID_W-1:0] stream_q;

  logic [sidr_pkg::SEL_W-1:0] sel_mask;
  logic                       in_acc;
  logic                       emit;
  logic                       match;
  logic                       issue;
  logic                       do_new;

  logic [FW-1:0]              fill_rdata;
  logic [IW-1:0]              slot_rdata;
  logic [sidr_pkg::ID_W-1:0]  id_rdata;
  logic [SAW-1:0]             slot_raddr;

  always_comb begin
    for (int unsigned b = 0; b < sidr_pkg::SEL_W; b++) begin
      sel_mask[b] = (b < 32'(shard_bits_q));
    end
    shard_d = SHARD_OF[user_id_i[sidr_pkg::SEL_LSB +: sidr_pkg::SEL_W] & sel_mask];
  end

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == sidr_pkg::S_IDLE);
  assign slot_raddr = base_q + SAW'(k_q);
  assign match      = (state_q == sidr_pkg::S_SCAN) && p2_v_q && (id_rdata == id_q);
  assign issue      = (state_q == sidr_pkg::S_SCAN) && (k_q != fill_q) && !match;
  assign emit       = (state_q == sidr_pkg::S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    fvalid_d     = fvalid_q;
    fill_d       = fill_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    p1_v_d       = issue;
    p2_v_d       = (state_q == sidr_pkg::S_SCAN) && p1_v_q && !match;
    do_new       = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      sidr_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = sidr_pkg::S_FILL;
        end
      end
      sidr_pkg::S_FILL: begin
        fill_d  = fvalid_q[shard_q] ? fill_rdata : '0;
        k_d     = '0;
        state_d = sidr_pkg::S_SCAN;
      end
      sidr_pkg::S_SCAN: begin
        if (issue) begin
          k_d = k_q + 1'b1;
        end
        if (match) begin
          res_status_d = sidr_pkg::ST_FOUND;
          res_idx_d    = p2_idx_q;
          state_d      = sidr_pkg::S_EMIT;
        end else if ((k_q == fill_q) && !p1_v_q && !p2_v_q) begin
          state_d = sidr_pkg::S_DECIDE;
        end
      end
      sidr_pkg::S_DECIDE: begin
        res_idx_d = '0;
        if (cmd_q == sidr_pkg::CMD_FIND) begin
          res_status_d = sidr_pkg::ST_MISSING;
        end else if ((total_q == CW'(CAPACITY)) || (fill_q == FW'(SHARD_SLOTS))) begin
          res_status_d = sidr_pkg::ST_FULL;
        end else begin
          do_new            = 1'b1;
          res_status_d      = sidr_pkg::ST_NEW;
          res_idx_d         = IW'(total_q);
          total_d           = total_q + 1'b1;
          fvalid_d[shard_q] = 1'b1;
        end
        state_d = sidr_pkg::S_EMIT;
      end
      sidr_pkg::S_EMIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          state_d     = sidr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sidr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sidr_pkg::S_IDLE;
      shard_bits_q <= '0;
      total_q      <= '0;
      fvalid_q     <= '0;
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      fvalid_q    <= fvalid_d;
      p1_v_q      <= p1_v_d;
      p2_v_q      <= p2_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        shard_bits_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q    <= user_id_i;
      cmd_q   <= command_i;
      shard_q <= shard_d;
      base_q  <= SAW'(shard_d) * SAW'(SHARD_SLOTS);
    end
    fill_q       <= fill_d;
    k_q          <= k_d;
    p2_idx_q     <= slot_rdata;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (emit) begin
      status_q <= res_status_q;
      stream_q <= sidr_pkg::SID_W'(res_idx_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign stream_id_o = stream_q;

  // per-shard fill counts
  sidr_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_SHARDS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (do_new),
    .waddr_i (shard_q),
    .wdata_i (fill_q + 1'b1),
    .raddr_i (shard_d),
    .rdata_o (fill_rdata)
  );

  // global index list of every shard
  sidr_ram #(
    .WIDTH (IW),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (do_new),
    .waddr_i (base_q + SAW'(fill_q)),
    .wdata_i (IW'(total_q)),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // stored ids by global index
  sidr_ram #(
    .WIDTH (sidr_pkg::ID_W),
    .DEPTH (CAPACITY)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (do_new),
    .waddr_i (IW'(total_q)),
    .wdata_i (id_q),
    .raddr_i (slot_rdata),
    .rdata_o (id_rdata)
  );

`ifndef SYNTHESIS
  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(CAPACITY))
    else $error("store count above capacity");

  a_new_bumps_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_new |=> (total_q == $past(total_q) + 1'b1))
    else $error("insert did not advance store count");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidr_pkg::S_SCAN) |-> (fill_q <= FW'(SHARD_SLOTS) && k_q <= fill_q))
    else $error("probe ran past shard fill");

  a_miss_zero_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sidr_pkg::ST_MISSING || status_o == sidr_pkg::ST_FULL)
      |-> (stream_id_o == '0))
    else $error("nonzero stream id on miss or full");
`endif

endmodule

[tb/sv/tb_sharded_id_registry_unit.sv]
// tb_sharded_id_registry_unit: self-checking bench for the sharded id registry
// depends on sidr_pkg and sharded_id_registry_unit; predicts every result word
// from its own copy of the registry and checks status and stream id in order
module tb_sharded_id_registry_unit;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned MAX_SHARDS  = 16;
  localparam int unsigned SHARD_SLOTS = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic        CMD_REGISTER = 1'b0;

  typedef struct {
    logic                      command;
    logic [sidr_pkg::ID_W-1:0] user_id;
  } lookup_req_t;

  typedef struct {
    sidr_pkg::status_e          status;
    logic [sidr_pkg::SID_W-1:0] stream_id;
  } registry_result_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [sidr_pkg::CFG_W-1:0]  cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        command_i = 1'b0;
  logic [sidr_pkg::ID_W-1:0]   user_id_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [1:0]                  status_o;
  logic [sidr_pkg::SID_W-1:0]  stream_id_o;

  // registry mirror
  logic [sidr_pkg::ID_W-1:0]   registry_ids [CAPACITY];
  logic [sidr_pkg::SID_W-1:0]  shard_slot [MAX_SHARDS][SHARD_SLOTS];
  int unsigned                 shard_count [MAX_SHARDS] = '{default: 0};
  int unsigned                 registered_total = 0;
  logic [sidr_pkg::CFG_W-1:0]  sel_bits = '0;

  lookup_req_t                 lookups_pending [$];
  registry_result_t            results_due [$];
  logic [sidr_pkg::ID_W-1:0]   seen_ids [$];
  lookup_req_t                 next_lookup;
  registry_result_t            expected_result;
  int unsigned                 lookups_issued = 0;
  int unsigned                 results_seen = 0;
  int unsigned                 fail_count = 0;
  int unsigned                 quiet_cycles = 0;
  int unsigned                 send_idle_pct = 0;
  int unsigned                 recv_stall_pct = 0;
  int unsigned                 phase_bits [7] = '{7, 0, 2, 1, 3, 5, 4};
  int unsigned                 phase_items [7] = '{175, 100, 175, 125, 175, 175, 300};

  sharded_id_registry_unit #(
    .CAPACITY   (CAPACITY),
    .MAX_SHARDS (MAX_SHARDS),
    .SHARD_SLOTS(SHARD_SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .user_id_i  (user_id_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .stream_id_o(stream_id_o)
  );

  function automatic registry_result_t registry_lookup(logic cmd,
                                                       logic [sidr_pkg::ID_W-1:0] uid);
    registry_result_t            res;
    logic [sidr_pkg::SEL_W-1:0]  sel_mask;
    int unsigned                 shard;
    int unsigned                 slot;
    bit                          hit;
    sel_mask = sidr_pkg::SEL_W'((1 << sel_bits) - 1);
    shard = (uid[sidr_pkg::SEL_LSB +: sidr_pkg::SEL_W] & sel_mask) % MAX_SHARDS;
    hit = 1'b0;
    res.status = sidr_pkg::ST_MISSING;
    res.stream_id = '0;
    for (slot = 0; slot < shard_count[shard] && !hit; slot++) begin
      if (registry_ids[shard_slot[shard][slot]] == uid) begin
        hit = 1'b1;
        res.status = sidr_pkg::ST_FOUND;
        res.stream_id = shard_slot[shard][slot];
      end
    end
    if (!hit && cmd != sidr_pkg::CMD_FIND) begin
      if (registered_total >= CAPACITY || shard_count[shard] >= SHARD_SLOTS) begin
        res.status = sidr_pkg::ST_FULL;
      end else begin
        registry_ids[registered_total] = uid;
        shard_slot[shard][shard_count[shard]] = sidr_pkg::SID_W'(registered_total);
        shard_count[shard]++;
        res.status = sidr_pkg::ST_NEW;
        res.stream_id = sidr_pkg::SID_W'(registered_total);
        registered_total++;
      end
    end
    return res;
  endfunction

  function automatic void queue_lookup(logic cmd, logic [sidr_pkg::ID_W-1:0] uid);
    lookup_req_t req;
    req.command = cmd;
    req.user_id = uid;
    lookups_pending.push_back(req);
    lookups_issued++;
    seen_ids.push_back(uid);
    if (seen_ids.size() > 96) seen_ids.delete(0);
  endfunction

  // fresh ids, repeats of known ids, near misses and finds of unknown ids;
  // spread mode registers fresh ids round robin over the shards to fill the store
  function automatic lookup_req_t random_lookup(int unsigned fresh_pct, bit spread,
                                                int unsigned rr);
    lookup_req_t req;
    int unsigned pick;
    pick = $urandom_range(99);
    req.user_id = {$urandom, $urandom};
    if ($urandom_range(99) < 40) begin
      req.user_id[sidr_pkg::SEL_LSB +: sidr_pkg::SEL_W] =
        sidr_pkg::SEL_W'($urandom_range(3));
    end
    req.command = ($urandom_range(99) < 85) ? CMD_REGISTER : sidr_pkg::CMD_FIND;
    if (spread) begin
      req.user_id[sidr_pkg::SEL_LSB +: 4] = rr[3:0];
      req.command = CMD_REGISTER;
    end else if (pick >= fresh_pct) begin
      if (pick < fresh_pct + 45 && seen_ids.size() != 0) begin
        req.user_id = seen_ids[$urandom_range(seen_ids.size() - 1)];
        req.command = 1'($urandom_range(1));
      end else if (pick < fresh_pct + 60 && seen_ids.size() != 0) begin
        req.user_id = seen_ids[$urandom_range(seen_ids.size() - 1)]
                      ^ (64'd1 << $urandom_range(63));
        req.command = 1'($urandom_range(1));
      end else begin
        req.command = sidr_pkg::CMD_FIND;
      end
    end
    return req;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i); while (results_seen != lookups_issued);
  endtask

  task automatic write_shard_bits(input logic [sidr_pkg::CFG_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sel_bits = value;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) results_due.push_back(registry_lookup(command_i, user_id_i));
      if (!in_valid_i || in_ready_o) begin
        if (lookups_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_lookup = lookups_pending.pop_front();
          in_valid_i <= 1'b1;
          command_i <= next_lookup.command;
          user_id_i <= next_lookup.user_id;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("unexpected result word: status %0d stream_id %0d", status_o, stream_id_o);
          fail_count++;
        end else begin
          expected_result = results_due.pop_front();
          results_seen++;
          if (status_o !== expected_result.status) begin
            $error("status: expected %0d, got %0d", expected_result.status, status_o);
            fail_count++;
          end
          if (stream_id_o !== expected_result.stream_id) begin
            $error("stream_id: expected %0d, got %0d", expected_result.stream_id, stream_id_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    lookup_req_t req;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_shard_bits(sidr_pkg::CFG_W'(0));

    // single shard: empty find, id extremes, repeats, then the shard runs full
    queue_lookup(sidr_pkg::CMD_FIND, 64'd0);
    queue_lookup(CMD_REGISTER, 64'd0);
    queue_lookup(CMD_REGISTER, 64'd0);
    queue_lookup(sidr_pkg::CMD_FIND, 64'd0);
    queue_lookup(CMD_REGISTER, '1);
    queue_lookup(sidr_pkg::CMD_FIND, '1);
    queue_lookup(sidr_pkg::CMD_FIND, 64'h8000_0000_0000_0000);
    for (int k = 0; k < 14; k++) begin
      queue_lookup(CMD_REGISTER, {~k[31:0], 32'(k * 32'h9E37_79B9)});
    end
    queue_lookup(CMD_REGISTER, 64'h0123_4567_89AB_CDEF);
    queue_lookup(sidr_pkg::CMD_FIND, 64'h0123_4567_89AB_CDEF);
    queue_lookup(CMD_REGISTER, 64'd0);

    for (int p = 0; p < 7; p++) begin
      write_shard_bits(sidr_pkg::CFG_W'(phase_bits[p]));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      for (int i = 0; i < phase_items[p]; i++) begin
        if (i == phase_items[p] / 2) wait_drained();
        req = random_lookup(20, p == 6, i);
        queue_lookup(req.command, req.user_id);
      end
    end

    wait_drained();
    repeat (SHARD_SLOTS + 16) @(posedge clk_i);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sharded_id_registry_unit.f]
hw/rtl/sidr_pkg.sv
hw/rtl/sidr_ram.sv
hw/rtl/sharded_id_registry_unit.sv
tb/sv/tb_sharded_id_registry_unit.sv
